// File: hw/rtl/cbf_pkg.sv
`timescale 1ns / 1ps

package cbf_pkg;

  localparam int POINTS_DEF = 100;
  localparam int COORD_W    = 24;
  localparam int IDX_W      = 7;

  localparam logic OP_LOAD    = 1'b0;
  localparam logic OP_ADVANCE = 1'b1;

  typedef enum logic [4:0] {
    ST_IDLE,
    ST_BB,
    ST_AA,
    ST_C0,
    ST_M0,
    ST_C1,
    ST_M1,
    ST_C2,
    ST_M2,
    ST_C3,
    ST_M3,
    ST_ACC,
    ST_ROUND,
    ST_EST,
    ST_QD,
    ST_FIX,
    ST_DONE
  } state_t;

  typedef enum logic [3:0] {
    MS_BB,
    MS_AA,
    MS_C0,
    MS_C1,
    MS_C2,
    MS_C3,
    MS_P0,
    MS_P1,
    MS_P2,
    MS_P3,
    MS_QD
  } mul_sel_t;

  typedef enum logic [1:0] {
    ACC_NONE,
    ACC_SET,
    ACC_ADD
  } acc_op_t;

  typedef struct packed {
    logic     load_pts;
    logic     start_step;
    logic     mul_en;
    mul_sel_t mul_sel;
    acc_op_t  acc_op;
    logic     round_en;
    logic     est_en;
    logic     fix_en;
    logic     out_load;
  } dp_cmd_t;

  typedef struct packed {
    logic step_last;
  } dp_status_t;

endpackage

// File: hw/rtl/cbf_datapath.sv
`timescale 1ns / 1ps

module cbf_datapath import cbf_pkg::*; #(
  parameter int POINTS = POINTS_DEF
) (
  input  logic                      clk,
  input  logic                      rst,
  input  dp_cmd_t                   cmd,
  output dp_status_t                status,
  input  logic signed [COORD_W-1:0] ctrl_start,
  input  logic signed [COORD_W-1:0] ctrl_first,
  input  logic signed [COORD_W-1:0] ctrl_second,
  input  logic signed [COORD_W-1:0] ctrl_end,
  output logic signed [COORD_W-1:0] sample,
  output logic [IDX_W-1:0]          sample_index,
  output logic                      last
);

  localparam int JW = $clog2(POINTS + 1);
  localparam int CW = 3 * JW;
  localparam int BW = COORD_W + 1;
  localparam int MW = CW + 1 + BW;
  localparam int AW = CW + 25;
  localparam int RW = AW - 1;
  localparam logic [RW-1:0] DEN  = RW'(POINTS * POINTS * POINTS);
  localparam logic [RW-1:0] HALF = DEN >> 1;
  localparam logic [CW-1:0] DEN_C = CW'(POINTS * POINTS * POINTS);
  localparam logic [JW-1:0] N_J  = JW'(POINTS);

  // quotient estimate: top XW bits of the dividend times a XW-bit reciprocal,
  // low by at most one, fixed by one compare and subtract
  localparam int     LD    = $clog2(POINTS * POINTS * POINTS);
  localparam int     XW    = 26;
  localparam int     SH    = LD - 2;
  localparam int     QS    = XW + 1;
  localparam longint DEN_L = longint'(POINTS) * POINTS * POINTS;
  localparam logic [XW-1:0] RECIP = XW'((longint'(1) << (LD + XW - 1)) / DEN_L);

  logic signed [COORD_W-1:0] pts [4];
  logic [JW-1:0]             step_cnt;
  logic [JW-1:0]             a;
  logic [JW-1:0]             b;
  logic [2*JW-1:0]           bb;
  logic [2*JW-1:0]           aa;
  logic [CW-1:0]             coef;
  logic signed [AW-1:0]      prod;
  logic signed [AW-1:0]      acc;
  logic                      neg;
  logic [RW-1:0]             rem;
  logic [COORD_W-1:0]        q;

  logic [JW-1:0]             step_inc;
  logic [CW-1:0]             opa;
  logic signed [BW-1:0]      opb;
  logic signed [MW-1:0]      mul_out;
  logic [CW-1:0]             mul_lo;
  logic [CW-1:0]             mul_x3;
  logic [AW-1:0]             mag;
  logic [JW-1:0]             jm1;
  logic [XW-1:0]             xh;
  logic [2*XW-1:0]           est_prod;
  logic [RW-1:0]             fix_rem;

  assign step_inc = step_cnt + 1'b1;
  assign status.step_last = (step_cnt == N_J - 1'b1);

  always_comb begin
    opa = coef;
    opb = BW'(pts[0]);
    unique case (cmd.mul_sel)
      MS_BB: begin
        opa = CW'(b);
        opb = signed'(BW'(b));
      end
      MS_AA: begin
        opa = CW'(a);
        opb = signed'(BW'(a));
      end
      MS_C0: begin
        opa = CW'(bb);
        opb = signed'(BW'(b));
      end
      MS_C1: begin
        opa = CW'(bb);
        opb = signed'(BW'(a));
      end
      MS_C2: begin
        opa = CW'(aa);
        opb = signed'(BW'(b));
      end
      MS_C3: begin
        opa = CW'(aa);
        opb = signed'(BW'(a));
      end
      MS_P0: opb = BW'(pts[0]);
      MS_P1: opb = BW'(pts[1]);
      MS_P2: opb = BW'(pts[2]);
      MS_P3: opb = BW'(pts[3]);
      MS_QD: begin
        opa = DEN_C;
        opb = signed'(BW'(q));
      end
      default: opb = BW'(pts[0]);
    endcase
  end

  assign mul_out  = signed'({1'b0, opa}) * opb;
  assign mul_lo   = mul_out[CW-1:0];
  assign mul_x3   = mul_lo + {mul_lo[CW-2:0], 1'b0};
  assign mag      = acc[AW-1] ? AW'(-acc) : AW'(acc);
  assign jm1      = a - 1'b1;
  assign xh       = rem[SH +: XW];
  assign est_prod = xh * RECIP;
  assign fix_rem  = rem - prod[RW-1:0];

  always_ff @(posedge clk) begin
    if (rst) begin
      step_cnt <= '0;
      for (int i = 0; i < 4; i++) begin
        pts[i] <= '0;
      end
    end else if (cmd.load_pts) begin
      step_cnt <= '0;
      pts[0]   <= ctrl_start;
      pts[1]   <= ctrl_first;
      pts[2]   <= ctrl_second;
      pts[3]   <= ctrl_end;
    end else if (cmd.start_step) begin
      step_cnt <= step_inc;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.start_step) begin
      a <= step_inc;
      b <= N_J - step_inc;
    end
    if (cmd.mul_en) begin
      unique case (cmd.mul_sel) inside
        MS_BB: bb <= mul_lo[2*JW-1:0];
        MS_AA: aa <= mul_lo[2*JW-1:0];
        MS_C0, MS_C3: coef <= mul_lo;
        MS_C1, MS_C2: coef <= mul_x3;
        default: prod <= mul_out[AW-1:0];
      endcase
    end
    unique case (cmd.acc_op)
      ACC_SET: acc <= prod;
      ACC_ADD: acc <= acc + prod;
      default: acc <= acc;
    endcase
    if (cmd.round_en) begin
      neg <= acc[AW-1];
      rem <= mag[RW-1:0] + HALF;
    end
    if (cmd.est_en) begin
      q <= est_prod[QS +: COORD_W];
    end else if (cmd.fix_en) begin
      if (fix_rem >= DEN) begin
        q <= q + 1'b1;
      end
    end
    if (cmd.out_load) begin
      sample       <= neg ? signed'(~q + 1'b1) : signed'(q);
      sample_index <= IDX_W'(jm1);
      last         <= (a == N_J);
    end
  end

endmodule

// File: hw/rtl/cbf_controller.sv
`timescale 1ns / 1ps

module cbf_controller import cbf_pkg::*; (
  input  logic       clk,
  input  logic       rst,
  input  logic       in_valid,
  output logic       in_stall,
  input  logic       opcode,
  output logic       out_valid,
  input  logic       out_stall,
  output dp_cmd_t    cmd,
  input  dp_status_t status
);

  state_t state;
  state_t state_next;
  logic   active;
  logic   active_next;
  logic   accept;
  logic   out_free;

  assign in_stall = (state != ST_IDLE);
  assign accept   = in_valid && !in_stall;
  assign out_free = !out_valid || !out_stall;

  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= ST_IDLE;
      active    <= 1'b0;
      out_valid <= 1'b0;
    end else begin
      state  <= state_next;
      active <= active_next;
      if (cmd.out_load) begin
        out_valid <= 1'b1;
      end else if (!out_stall) begin
        out_valid <= 1'b0;
      end
    end
  end

  always_comb begin
    state_next  = state;
    active_next = active;
    cmd         = '{
      load_pts:   1'b0,
      start_step: 1'b0,
      mul_en:     1'b0,
      mul_sel:    MS_BB,
      acc_op:     ACC_NONE,
      round_en:   1'b0,
      est_en:     1'b0,
      fix_en:     1'b0,
      out_load:   1'b0
    };
    unique case (state)
      ST_IDLE: begin
        if (accept) begin
          if (opcode == OP_LOAD) begin
            cmd.load_pts = 1'b1;
            active_next  = 1'b1;
          end else if (active) begin
            cmd.start_step = 1'b1;
            active_next    = !status.step_last;
            state_next     = ST_BB;
          end
        end
      end
      ST_BB: begin
        cmd.mul_en  = 1'b1;
        cmd.mul_sel = MS_BB;
        state_next  = ST_AA;
      end
      ST_AA: begin
        cmd.mul_en  = 1'b1;
        cmd.mul_sel = MS_AA;
        state_next  = ST_C0;
      end
      ST_C0: begin
        cmd.mul_en  = 1'b1;
        cmd.mul_sel = MS_C0;
        state_next  = ST_M0;
      end
      ST_M0: begin
        cmd.mul_en  = 1'b1;
        cmd.mul_sel = MS_P0;
        state_next  = ST_C1;
      end
      ST_C1: begin
        cmd.mul_en  = 1'b1;
        cmd.mul_sel = MS_C1;
        cmd.acc_op  = ACC_SET;
        state_next  = ST_M1;
      end
      ST_M1: begin
        cmd.mul_en  = 1'b1;
        cmd.mul_sel = MS_P1;
        state_next  = ST_C2;
      end
      ST_C2: begin
        cmd.mul_en  = 1'b1;
        cmd.mul_sel = MS_C2;
        cmd.acc_op  = ACC_ADD;
        state_next  = ST_M2;
      end
      ST_M2: begin
        cmd.mul_en  = 1'b1;
        cmd.mul_sel = MS_P2;
        state_next  = ST_C3;
      end
      ST_C3: begin
        cmd.mul_en  = 1'b1;
        cmd.mul_sel = MS_C3;
        cmd.acc_op  = ACC_ADD;
        state_next  = ST_M3;
      end
      ST_M3: begin
        cmd.mul_en  = 1'b1;
        cmd.mul_sel = MS_P3;
        state_next  = ST_ACC;
      end
      ST_ACC: begin
        cmd.acc_op = ACC_ADD;
        state_next = ST_ROUND;
      end
      ST_ROUND: begin
        cmd.round_en = 1'b1;
        state_next   = ST_EST;
      end
      ST_EST: begin
        cmd.est_en = 1'b1;
        state_next = ST_QD;
      end
      ST_QD: begin
        cmd.mul_en  = 1'b1;
        cmd.mul_sel = MS_QD;
        state_next  = ST_FIX;
      end
      ST_FIX: begin
        cmd.fix_en = 1'b1;
        state_next = ST_DONE;
      end
      ST_DONE: begin
        if (out_free) begin
          cmd.out_load = 1'b1;
          state_next   = ST_IDLE;
        end
      end
      default: state_next = ST_IDLE;
    endcase
  end

endmodule

// File: hw/rtl/cubic_bezier_flattener_unit.sv
// One axis of a cubic Bezier segment is flattened into POINTS samples at t = j/POINTS.
// A load request (opcode 0) stores the four coordinates; each advance request (opcode 1)
// then yields the next sample, rounded half away from zero, with last set on the final one;
// advances with no curve pending are taken and dropped without stalling the input. An
// advance keeps the input stalled while its sample is computed, so no new request is taken
// before it is through: the shared multiplier (22x25 at the default POINTS) builds the
// Bernstein weights and products, the sum is rounded, the result is divided by POINTS cubed
// (reciprocal multiply, back-multiply, one correction step) and loaded into the output
// register. The next request is taken while a result waits there; the input stays stalled
// as long as a following result is ready and the previous one has not gone.
`timescale 1ns / 1ps

module cubic_bezier_flattener_unit import cbf_pkg::*; #(
  parameter int POINTS = POINTS_DEF
) (
  input  logic                      clk,
  input  logic                      rst,
  input  logic                      in_valid,
  output logic                      in_stall,
  input  logic                      opcode,
  input  logic signed [COORD_W-1:0] ctrl_start,
  input  logic signed [COORD_W-1:0] ctrl_first,
  input  logic signed [COORD_W-1:0] ctrl_second,
  input  logic signed [COORD_W-1:0] ctrl_end,
  output logic                      out_valid,
  input  logic                      out_stall,
  output logic signed [COORD_W-1:0] sample,
  output logic [IDX_W-1:0]          sample_index,
  output logic                      last
);

  dp_cmd_t    cmd;
  dp_status_t status;

  cbf_controller u_ctrl (
    .clk       (clk),
    .rst       (rst),
    .in_valid  (in_valid),
    .in_stall  (in_stall),
    .opcode    (opcode),
    .out_valid (out_valid),
    .out_stall (out_stall),
    .cmd       (cmd),
    .status    (status)
  );

  cbf_datapath #(
    .POINTS (POINTS)
  ) u_dp (
    .clk          (clk),
    .rst          (rst),
    .cmd          (cmd),
    .status       (status),
    .ctrl_start   (ctrl_start),
    .ctrl_first   (ctrl_first),
    .ctrl_second  (ctrl_second),
    .ctrl_end     (ctrl_end),
    .sample       (sample),
    .sample_index (sample_index),
    .last         (last)
  );

`ifndef SYNTHESIS
  a_load_one_cycle: assert property (@(posedge clk) disable iff (rst)
    in_valid && !in_stall && (opcode == OP_LOAD) |=> !in_stall)
    else $error("load request kept input stalled");

  a_last_index: assert property (@(posedge clk) disable iff (rst)
    out_valid && last |-> sample_index == IDX_W'(POINTS - 1))
    else $error("last sample has wrong index");

  a_result_after_work: assert property (@(posedge clk) disable iff (rst)
    $rose(out_valid) |-> $past(in_stall))
    else $error("result appeared without computation");
`endif

endmodule

// File: dv/cubic_bezier_flattener_unit_tb.sv
`timescale 1ns / 1ps

module cubic_bezier_flattener_unit_tb;
  import cbf_pkg::*;

  localparam int NPTS = POINTS_DEF;
  localparam int RAND_ITEMS = 1850;
  localparam logic signed [COORD_W-1:0] CMAX = {1'b0, {(COORD_W-1){1'b1}}};
  localparam logic signed [COORD_W-1:0] CMIN = {1'b1, {(COORD_W-1){1'b0}}};

  typedef struct {
    logic                      op;
    logic signed [COORD_W-1:0] c_start;
    logic signed [COORD_W-1:0] c_first;
    logic signed [COORD_W-1:0] c_second;
    logic signed [COORD_W-1:0] c_end;
    bit                        hold_back;
  } req_t;

  typedef struct {
    logic signed [COORD_W-1:0] value;
    logic [IDX_W-1:0]          idx;
    logic                      fin;
  } sample_t;

  logic                      clk = 1'b0;
  logic                      rst = 1'b1;
  logic                      in_valid = 1'b0;
  logic                      in_stall;
  logic                      opcode = OP_LOAD;
  logic signed [COORD_W-1:0] ctrl_start = '0;
  logic signed [COORD_W-1:0] ctrl_first = '0;
  logic signed [COORD_W-1:0] ctrl_second = '0;
  logic signed [COORD_W-1:0] ctrl_end = '0;
  logic                      out_valid;
  logic                      out_stall = 1'b0;
  logic signed [COORD_W-1:0] sample;
  logic [IDX_W-1:0]          sample_index;
  logic                      last;

  req_t    req_q[$];
  sample_t pending_samples[$];

  longint curve_pt[4];
  int     steps_done = 0;
  bit     curve_live = 1'b0;

  int gap_left = 0;
  int calm_items = 0;
  int n_accepted = 0;
  int stall_left = 0;
  int calm_cycles = 0;
  int hold_cycles = 0;
  int holds_done = 0;

  int mismatches = 0;
  int n_loads = 0;
  int n_advances = 0;
  int n_dropped = 0;
  int n_checked = 0;
  int n_curves = 0;

  cubic_bezier_flattener_unit #(.POINTS(NPTS)) DUT (
    .clk          (clk),
    .rst          (rst),
    .in_valid     (in_valid),
    .in_stall     (in_stall),
    .opcode       (opcode),
    .ctrl_start   (ctrl_start),
    .ctrl_first   (ctrl_first),
    .ctrl_second  (ctrl_second),
    .ctrl_end     (ctrl_end),
    .out_valid    (out_valid),
    .out_stall    (out_stall),
    .sample       (sample),
    .sample_index (sample_index),
    .last         (last)
  );

  initial begin
    forever #10 clk = ~clk;
  end

  function automatic int pick_gap();
    int r;
    r = $urandom_range(0, 99);
    if (r < 55) return 0;
    if (r < 85) return $urandom_range(1, 3);
    if (r < 97) return $urandom_range(4, 15);
    return $urandom_range(30, 120);
  endfunction

  function automatic logic signed [COORD_W-1:0] rand_coord();
    int r;
    r = $urandom_range(0, 99);
    if (r < 40) return COORD_W'($urandom);
    if (r < 60) return COORD_W'($urandom_range(0, 1200) - 600);
    if (r < 75) begin
      case ($urandom_range(0, 4))
        0: return CMAX;
        1: return CMIN;
        2: return '0;
        3: return COORD_W'(-1);
        default: return COORD_W'(1);
      endcase
    end
    return COORD_W'($urandom_range(0, 131071) - 65536);
  endfunction

  function automatic void add_req(logic op, logic signed [COORD_W-1:0] p0,
                                  logic signed [COORD_W-1:0] p1,
                                  logic signed [COORD_W-1:0] p2,
                                  logic signed [COORD_W-1:0] p3);
    req_t r;
    r.op = op;
    r.c_start = p0;
    r.c_first = p1;
    r.c_second = p2;
    r.c_end = p3;
    // sender waits for all outstanding samples at these points
    r.hold_back = (req_q.size() == 500) || (req_q.size() == 1500);
    req_q.insert(req_q.size(), r);
  endfunction

  function automatic void add_advance();
    add_req(OP_ADVANCE, rand_coord(), rand_coord(), rand_coord(), rand_coord());
  endfunction

  // exact Bernstein numerator over N^3, rounded half away from zero
  function automatic longint bernstein_round(int j);
    longint n, a, b, num, den, mag, q;
    n = NPTS;
    a = j;
    b = n - a;
    num = b * b * b * curve_pt[0] + 3 * a * b * b * curve_pt[1]
        + 3 * a * a * b * curve_pt[2] + a * a * a * curve_pt[3];
    den = n * n * n;
    mag = (num < 0) ? -num : num;
    q = (mag + den / 2) / den;
    return (num < 0) ? -q : q;
  endfunction

  function automatic void track_request(logic op, logic signed [COORD_W-1:0] p0,
                                        logic signed [COORD_W-1:0] p1,
                                        logic signed [COORD_W-1:0] p2,
                                        logic signed [COORD_W-1:0] p3);
    sample_t s;
    longint  q;
    int      j;
    if (op == OP_LOAD) begin
      curve_pt[0] = p0;
      curve_pt[1] = p1;
      curve_pt[2] = p2;
      curve_pt[3] = p3;
      steps_done = 0;
      curve_live = 1'b1;
      n_loads++;
    end else if (curve_live) begin
      j = steps_done + 1;
      q = bernstein_round(j);
      s.value = q[COORD_W-1:0];
      s.idx = IDX_W'(j - 1);
      s.fin = (j >= NPTS);
      pending_samples.insert(pending_samples.size(), s);
      steps_done = j;
      if (s.fin) curve_live = 1'b0;
      n_advances++;
    end else begin
      n_dropped++;
    end
  endfunction

  function automatic void note_mismatch(string msg);
    mismatches++;
    if (mismatches <= 10) $display("MISMATCH @%0t: %s", $time, msg);
  endfunction

  function automatic void check_sample();
    sample_t want;
    if (pending_samples.size() == 0) begin
      note_mismatch($sformatf("unexpected sample %0d idx %0d last %0b",
                              sample, sample_index, last));
    end else begin
      want = pending_samples.pop_front();
      n_checked++;
      if (last) n_curves++;
      if (sample !== want.value)
        note_mismatch($sformatf("sample exp %0d got %0d (idx %0d)",
                                want.value, sample, want.idx));
      if (sample_index !== want.idx)
        note_mismatch($sformatf("sample_index exp %0d got %0d", want.idx, sample_index));
      if (last !== want.fin)
        note_mismatch($sformatf("last exp %0b got %0b (idx %0d)", want.fin, last, want.idx));
    end
  endfunction

  // request driver
  always @(posedge clk) begin
    req_t nxt;
    if (rst) begin
      in_valid <= 1'b0;
      gap_left <= 0;
    end else begin
      if (in_valid && !in_stall) begin
        track_request(opcode, ctrl_start, ctrl_first, ctrl_second, ctrl_end);
        n_accepted <= n_accepted + 1;
      end
      if (!in_valid || !in_stall) begin
        if (gap_left != 0) begin
          gap_left <= gap_left - 1;
          in_valid <= 1'b0;
        end else if (req_q.size() != 0 &&
                     !(req_q[0].hold_back && pending_samples.size() != 0)) begin
          nxt = req_q.pop_front();
          in_valid <= 1'b1;
          opcode <= nxt.op;
          ctrl_start <= nxt.c_start;
          ctrl_first <= nxt.c_first;
          ctrl_second <= nxt.c_second;
          ctrl_end <= nxt.c_end;
          if (calm_items != 0) begin
            calm_items <= calm_items - 1;
            gap_left <= 0;
          end else begin
            gap_left <= pick_gap();
            if ($urandom_range(0, 99) < 3) calm_items <= 60;
          end
        end else begin
          in_valid <= 1'b0;
        end
      end
    end
  end

  // long receiver hold-off so the block backs up into its input
  always @(posedge clk) begin
    if (rst) begin
      hold_cycles <= 0;
    end else if (hold_cycles != 0) begin
      hold_cycles <= hold_cycles - 1;
    end else if ((holds_done == 0 && n_accepted >= 300) ||
                 (holds_done == 1 && n_accepted >= 1300)) begin
      hold_cycles <= 700;
      holds_done <= holds_done + 1;
    end
  end

  // result monitor
  always @(posedge clk) begin
    int r;
    if (rst) begin
      out_stall <= 1'b0;
      stall_left <= 0;
      calm_cycles <= 0;
    end else begin
      if (out_valid && !out_stall) check_sample();
      r = $urandom_range(0, 99);
      if (hold_cycles != 0) begin
        out_stall <= 1'b1;
      end else if (stall_left != 0) begin
        stall_left <= stall_left - 1;
        out_stall <= 1'b1;
      end else if (calm_cycles != 0) begin
        calm_cycles <= calm_cycles - 1;
        out_stall <= 1'b0;
      end else if (r < 1) begin
        calm_cycles <= 300;
        out_stall <= 1'b0;
      end else if (r < 20) begin
        stall_left <= pick_gap();
        out_stall <= 1'b1;
      end else begin
        out_stall <= 1'b0;
      end
    end
  end

  initial begin
    int counted;
    int gen_steps;
    int kind;
    int n_adv;

    // directed: advance with nothing loaded, extreme coordinates, ignored fields,
    // rounding near zero, reload in mid-curve
    add_advance();
    add_req(OP_LOAD, CMAX, CMAX, CMAX, CMAX);
    add_advance();
    add_advance();
    add_req(OP_LOAD, CMIN, CMIN, CMIN, CMIN);
    add_advance();
    add_advance();
    add_req(OP_LOAD, CMIN, CMAX, CMIN, CMAX);
    add_advance();
    add_advance();
    add_req(OP_LOAD, CMAX, CMIN, CMAX, CMIN);
    add_req(OP_ADVANCE, CMAX, CMIN, CMAX, CMIN);
    add_req(OP_ADVANCE, CMIN, CMAX, COORD_W'(-1), COORD_W'(1));
    add_advance();
    add_req(OP_LOAD, '0, '0, '0, '0);
    add_advance();
    add_req(OP_LOAD, COORD_W'(-1), COORD_W'(1), COORD_W'(-1), COORD_W'(1));
    add_advance();
    add_advance();
    add_req(OP_LOAD, COORD_W'(1), '0, '0, COORD_W'(-1));
    add_advance();
    add_req(OP_LOAD, 24'sd100, -24'sd200, 24'sd300, -24'sd400);
    add_advance();
    add_advance();

    // random curves: mostly full runs past the end, some cut short by a reload
    counted = 0;
    gen_steps = 0;
    while (counted < RAND_ITEMS) begin
      kind = $urandom_range(0, 99);
      add_req(OP_LOAD, rand_coord(), rand_coord(), rand_coord(), rand_coord());
      counted++;
      gen_steps = 0;
      if (kind < 55) n_adv = NPTS + $urandom_range(0, 3);
      else if (kind < 85) n_adv = $urandom_range(1, NPTS - 1);
      else n_adv = $urandom_range(0, 5);
      for (int k = 0; k < n_adv; k++) begin
        add_advance();
        if (gen_steps < NPTS) begin
          gen_steps++;
          counted++;
        end
      end
    end

    repeat (11) @(posedge clk);
    rst <= 1'b0;
    @(negedge clk);
    while (req_q.size() != 0 || in_valid || pending_samples.size() != 0) @(negedge clk);
    repeat (120) @(negedge clk);

    $display("Run covered %0d loads and %0d advances (%0d dropped with no curve pending);",
             n_loads, n_advances, n_dropped);
    $display("%0d samples compared, %0d curves run to their last sample, %0d mismatches.",
             n_checked, n_curves, mismatches);
    if (mismatches == 0) begin
      $display("cubic_bezier_flattener_unit test passed");
    end else begin
      $display("cubic_bezier_flattener_unit test failed");
    end
    $finish;
  end

  initial begin
    #100_000_000;
    $display("Timeout: %0d requests accepted, %0d samples outstanding",
             n_accepted, pending_samples.size());
    $display("cubic_bezier_flattener_unit test failed");
    $finish;
  end

endmodule
